>>> rtl/assert_macros.svh
// Assertion macros of the allocator datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define BBA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define BBA_ASSERT_IMPLY(lbl, pre, post, msg) \
    `BBA_ASSERT(lbl, (pre) |-> (post), msg)
`else
`define BBA_ASSERT(lbl, prop, msg)
`define BBA_ASSERT_IMPLY(lbl, pre, post, msg)
`endif
`endif

>>> rtl/bba_pkg.sv
// Types, constants and helpers of the buddy block allocator.
`default_nettype none
package bba_pkg;
    localparam int DEF_MIN_ORDER  = 12;
    localparam int DEF_NUM_ORDERS = 11;
    localparam int DEF_POOL_UNITS = 4096;

    localparam int CNT_W     = 13;
    localparam int ADDR_W    = 48;
    localparam int SIZE_W    = 32;
    localparam int ORD_W     = 6;
    localparam int STAT_W    = 3;
    localparam int TOP_W     = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 48;
    localparam int S_DATA_W  = 88;
    localparam int M_DATA_W  = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOP_BLOCKS = 2'd1;
    localparam logic [TOP_W-1:0]     TOP_RESET      = 3'd4;

    typedef enum logic [STAT_W-1:0] {
        RES_OK        = 3'd0,
        RES_NOMEM     = 3'd1,
        RES_BAD_SIZE  = 3'd2,
        RES_BAD_ORDER = 3'd3,
        RES_BAD_BLOCK = 3'd4
    } res_t;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_CHECK, S_SCAN_RD, S_SCAN_CHK,
        S_RMW_RD, S_RMW_WR, S_FREE_RD, S_FREE_WR, S_DONE
    } state_t;

    typedef struct packed {
        logic load_in;
        logic check;
        logic clr_step;
        logic scan_rd;
        logic scan_chk;
        logic rmw_wr;
        logic free_wr;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic top_wr;
        logic clr_last;
        logic chk_fail;
        logic is_free;
        logic scan_hit;
        logic scan_last;
        logic split_more;
        logic merge;
        logic out_full;
    } sts_t;

    // First bit of a level in the packed bitmap
    function automatic int level_start(input int units, input int lv);
        return 2 * units - 2 * (units >> lv);
    endfunction
endpackage
`default_nettype wire

>>> rtl/bba_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module bba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

>>> rtl/bba_dp.sv
// Datapath of the buddy allocator: registers, bitmap RAM, counts and checks.
`default_nettype none
`include "assert_macros.svh"
module bba_dp import bba_pkg::*; #(
    parameter int MIN_ORDER  = DEF_MIN_ORDER,
    parameter int NUM_ORDERS = DEF_NUM_ORDERS,
    parameter int POOL_UNITS = DEF_POOL_UNITS
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_valid,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    input  wire logic [S_DATA_W-1:0]  s_tdata,
    input  wire logic                 s_tuser,
    input  wire logic                 m_tready,
    output logic                      m_tvalid,
    output logic [M_DATA_W-1:0]       m_tdata,
    input  wire cmd_t                 cmd,
    output sts_t                      sts
);
    localparam int MAXO     = MIN_ORDER + NUM_ORDERS - 1;
    localparam int TOP_MAX  = POOL_UNITS >> (NUM_ORDERS - 1);
    localparam int MAP_BITS = 2 * POOL_UNITS;
    localparam int WW       = (MAP_BITS >= 32) ? 32 : MAP_BITS;
    localparam int LW       = $clog2(WW);
    localparam int DEPTH    = MAP_BITS / WW;
    localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int GW       = $clog2(MAP_BITS);
    localparam int IW       = $clog2(POOL_UNITS);
    localparam int LVW      = $clog2(NUM_ORDERS);
    localparam int TOP_ST   = level_start(POOL_UNITS, NUM_ORDERS - 1);

    logic [ADDR_W-1:0]  pool_base_reg;
    logic [TOP_W-1:0]   top_reg;
    logic               op_reg;
    logic [SIZE_W-1:0]  size_reg;
    logic [ADDR_W-1:0]  faddr_reg;
    logic [ORD_W-1:0]   ford_reg;
    res_t               res_reg;
    logic [LVW-1:0]     lv_reg;
    logic [LVW-1:0]     tgt_reg;
    logic [IW-1:0]      idx_reg;
    logic [AW-1:0]      word_reg;
    logic               first_reg;
    logic [AW-1:0]      clr_reg;
    logic [CNT_W-1:0]   cnt_reg [NUM_ORDERS];
    logic               m_valid_reg;
    logic [M_DATA_W-1:0] m_data_reg;

    logic [TOP_W-1:0]   eff_t;
    logic               top_wr;
    logic [GW-1:0]      cur_ls;
    logic [IW:0]        cur_cap;
    logic [GW-1:0]      g_cur;
    logic [AW-1:0]      word_cur;
    logic [LW-1:0]      bp;
    logic [LW-1:0]      bud_bp;
    logic [AW-1:0]      word_end;
    logic [WW-1:0]      ram_rdata;
    logic [WW-1:0]      ram_wdata;
    logic [AW-1:0]      ram_raddr;
    logic [AW-1:0]      ram_waddr;
    logic               ram_we;
    logic [WW-1:0]      clr_word;

    logic [LVW-1:0]     tgt_c;
    logic               size_ok;
    logic [LVW-1:0]     lvf;
    logic               found;
    logic [AW-1:0]      lvf_word;
    logic [ADDR_W-1:0]  off;
    logic               ord_ok;
    logic               misal;
    logic               inpool;
    res_t               chk_res;
    logic               hit;
    logic [IW-1:0]      hit_idx;
    logic               merge;
    logic [IW-1:0]      bud;
    logic [ADDR_W-1:0]  grant_c;

    assign top_wr = cfg_valid && (cfg_index == CFG_TOP_BLOCKS);

    always_comb begin
        if (top_reg == '0) begin
            eff_t = TOP_W'(1);
        end else if (32'(top_reg) > TOP_MAX) begin
            eff_t = TOP_W'(TOP_MAX);
        end else begin
            eff_t = top_reg;
        end
    end

    // Level geometry of the level in hand
    always_comb begin
        cur_ls  = '0;
        cur_cap = '0;
        for (int i = 0; i < NUM_ORDERS; i++) begin
            if (lv_reg == LVW'(i)) begin
                cur_ls  = GW'(level_start(POOL_UNITS, i));
                cur_cap = (IW+1)'(POOL_UNITS >> i);
            end
        end
    end

    assign g_cur    = cur_ls + GW'(idx_reg);
    assign word_cur = AW'(g_cur >> LW);
    assign bp       = g_cur[LW-1:0];
    assign bud_bp   = bp ^ LW'(1);
    assign bud      = idx_reg ^ IW'(1);
    assign word_end = AW'((32'(cur_ls) + 32'(cur_cap) - 1) >> LW);

    // Allocate checks
    always_comb begin
        tgt_c   = '0;
        size_ok = 1'b0;
        for (int t = NUM_ORDERS - 1; t >= 0; t--) begin
            if ({32'b0, size_reg} <= (64'(1) << (MIN_ORDER + t))) begin
                tgt_c   = LVW'(t);
                size_ok = 1'b1;
            end
        end
        if (size_reg == '0) begin
            size_ok = 1'b0;
        end
        lvf      = '0;
        found    = 1'b0;
        lvf_word = '0;
        for (int i = NUM_ORDERS - 1; i >= 0; i--) begin
            if (LVW'(i) >= tgt_c && cnt_reg[i] != '0) begin
                lvf      = LVW'(i);
                found    = 1'b1;
                lvf_word = AW'(level_start(POOL_UNITS, i) >> LW);
            end
        end
    end

    // Free checks
    assign off    = faddr_reg - pool_base_reg;
    assign ord_ok = (32'(ford_reg) >= MIN_ORDER) && (32'(ford_reg) <= MAXO);
    assign inpool = (off >> MAXO) < ADDR_W'(eff_t);

    always_comb begin
        misal = 1'b0;
        for (int k = 0; k < ADDR_W; k++) begin
            if (k < 32'(ford_reg) && off[k]) begin
                misal = 1'b1;
            end
        end
    end

    always_comb begin
        if (!op_reg) begin
            if (!size_ok) begin
                chk_res = RES_BAD_SIZE;
            end else if (!found) begin
                chk_res = RES_NOMEM;
            end else begin
                chk_res = RES_OK;
            end
        end else begin
            if (!ord_ok) begin
                chk_res = RES_BAD_ORDER;
            end else if (faddr_reg < pool_base_reg || !inpool || misal) begin
                chk_res = RES_BAD_BLOCK;
            end else begin
                chk_res = RES_OK;
            end
        end
    end

    // Lowest free slot of the level in the word just read
    always_comb begin
        int g;
        hit     = 1'b0;
        hit_idx = '0;
        for (int b = WW - 1; b >= 0; b--) begin
            g = (32'(word_reg) << LW) + b;
            if (g >= 32'(cur_ls) && g < 32'(cur_ls) + 32'(cur_cap) && !ram_rdata[b]) begin
                hit     = 1'b1;
                hit_idx = IW'(g - 32'(cur_ls));
            end
        end
    end

    assign merge = (32'(lv_reg) < NUM_ORDERS - 1)
                && (32'(bud) < (32'(eff_t) << (NUM_ORDERS - 1 - 32'(lv_reg))))
                && !ram_rdata[bud_bp];

    always_comb begin
        int g;
        for (int b = 0; b < WW; b++) begin
            g = (32'(clr_reg) << LW) + b;
            clr_word[b] = !(g >= TOP_ST && g < TOP_ST + 32'(eff_t));
        end
    end

    always_comb begin
        ram_wdata = ram_rdata;
        if (cmd.clr_step) begin
            ram_wdata = clr_word;
        end else if (cmd.rmw_wr) begin
            ram_wdata[bp] = 1'b1;
            if (!first_reg) begin
                ram_wdata[bud_bp] = 1'b0;
            end
        end else if (cmd.free_wr) begin
            if (merge) begin
                ram_wdata[bp]     = 1'b1;
                ram_wdata[bud_bp] = 1'b1;
            end else begin
                ram_wdata[bp] = 1'b0;
            end
        end
    end

    assign ram_we    = cmd.clr_step || cmd.rmw_wr || cmd.free_wr;
    assign ram_waddr = cmd.clr_step ? clr_reg : word_cur;
    assign ram_raddr = cmd.scan_rd ? word_reg : word_cur;

    bba_ram #(.WIDTH(WW), .DEPTH(DEPTH), .AW(AW)) u_map (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign grant_c = pool_base_reg + ADDR_W'(64'(idx_reg) << (MIN_ORDER + 32'(tgt_reg)));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pool_base_reg <= '0;
            top_reg       <= TOP_RESET;
            clr_reg       <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_valid && cfg_index == CFG_POOL_BASE) begin
                pool_base_reg <= cfg_data[ADDR_W-1:0];
            end
            if (top_wr) begin
                top_reg <= cfg_data[TOP_W-1:0];
                clr_reg <= '0;
            end else if (cmd.clr_step) begin
                clr_reg <= clr_reg + AW'(1);
            end
            if (cmd.finish) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.clr_step && sts.clr_last) begin
            for (int i = 0; i < NUM_ORDERS; i++) begin
                cnt_reg[i] <= (i == NUM_ORDERS - 1) ? CNT_W'(eff_t) : '0;
            end
        end
        if (cmd.load_in) begin
            op_reg    <= s_tuser;
            size_reg  <= s_tdata[31:0];
            faddr_reg <= s_tdata[79:32];
            ford_reg  <= s_tdata[85:80];
        end
        if (cmd.check) begin
            res_reg   <= chk_res;
            tgt_reg   <= tgt_c;
            first_reg <= 1'b1;
            if (op_reg) begin
                lv_reg  <= LVW'(32'(ford_reg) - MIN_ORDER);
                idx_reg <= IW'(off >> ford_reg);
            end else begin
                lv_reg   <= lvf;
                word_reg <= lvf_word;
            end
        end
        if (cmd.scan_chk) begin
            if (hit) begin
                idx_reg <= hit_idx;
            end else if (sts.scan_last) begin
                res_reg <= RES_NOMEM;
            end else begin
                word_reg <= word_reg + AW'(1);
            end
        end
        if (cmd.rmw_wr) begin
            first_reg <= 1'b0;
            // take the slot, or keep the left half and free the right one
            if (first_reg) begin
                cnt_reg[lv_reg] <= cnt_reg[lv_reg] - CNT_W'(1);
            end else begin
                cnt_reg[lv_reg] <= cnt_reg[lv_reg] + CNT_W'(1);
            end
            if (lv_reg > tgt_reg) begin
                lv_reg  <= lv_reg - LVW'(1);
                idx_reg <= {idx_reg[IW-2:0], 1'b0};
            end
        end
        if (cmd.free_wr) begin
            if (merge) begin
                cnt_reg[lv_reg] <= cnt_reg[lv_reg] - CNT_W'(1);
                lv_reg  <= lv_reg + LVW'(1);
                idx_reg <= idx_reg >> 1;
            end else begin
                cnt_reg[lv_reg] <= cnt_reg[lv_reg] + CNT_W'(1);
            end
        end
        if (cmd.finish) begin
            if (res_reg == RES_OK && !op_reg) begin
                m_data_reg <= {7'b0, ORD_W'(MIN_ORDER + 32'(tgt_reg)), grant_c, res_reg};
            end else begin
                m_data_reg <= {7'b0, ORD_W'(0), ADDR_W'(0), res_reg};
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    always_comb begin
        sts.top_wr     = top_wr;
        sts.clr_last   = clr_reg == AW'(DEPTH - 1);
        sts.chk_fail   = chk_res != RES_OK;
        sts.is_free    = op_reg;
        sts.scan_hit   = hit;
        sts.scan_last  = word_reg == word_end;
        sts.split_more = lv_reg > tgt_reg;
        sts.merge      = merge;
        sts.out_full   = m_valid_reg && !m_tready;
    end

    `BBA_ASSERT_IMPLY(a_scan_in_level, cmd.scan_chk, word_reg <= word_end, "scan past level")
    `BBA_ASSERT_IMPLY(a_word_valid_rise, $rose(m_valid_reg), $past(cmd.finish), "stray result")
    `BBA_ASSERT_IMPLY(a_free_rmw_addr, cmd.free_wr, ram_waddr == $past(ram_raddr), "rmw addr moved")
endmodule
`default_nettype wire

>>> rtl/bba_ctrl.sv
// Controller state machine of the buddy allocator.
`default_nettype none
module bba_ctrl import bba_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_tvalid,
    output logic      s_tready,
    input  wire sts_t sts,
    output cmd_t      cmd
);
    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:    if (sts.clr_last) state_next = S_IDLE;
            S_IDLE:     if (s_tvalid) state_next = S_CHECK;
            S_CHECK: begin
                if (sts.chk_fail) state_next = S_DONE;
                else if (sts.is_free) state_next = S_FREE_RD;
                else state_next = S_SCAN_RD;
            end
            S_SCAN_RD:  state_next = S_SCAN_CHK;
            S_SCAN_CHK: begin
                if (sts.scan_hit) state_next = S_RMW_RD;
                else if (sts.scan_last) state_next = S_DONE;
                else state_next = S_SCAN_RD;
            end
            S_RMW_RD:   state_next = S_RMW_WR;
            S_RMW_WR:   state_next = sts.split_more ? S_RMW_RD : S_DONE;
            S_FREE_RD:  state_next = S_FREE_WR;
            S_FREE_WR:  state_next = sts.merge ? S_FREE_RD : S_DONE;
            S_DONE:     if (!sts.out_full) state_next = S_IDLE;
            default:    state_next = S_CLEAR;
        endcase
        // restart the sweep on a new pool size
        if (sts.top_wr) begin
            state_next = S_CLEAR;
        end
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            S_CLEAR:    cmd.clr_step = !sts.top_wr;
            S_IDLE: begin
                s_tready    = 1'b1;
                cmd.load_in = s_tvalid;
            end
            S_CHECK:    cmd.check    = 1'b1;
            S_SCAN_RD:  cmd.scan_rd  = 1'b1;
            S_SCAN_CHK: cmd.scan_chk = 1'b1;
            S_RMW_WR:   cmd.rmw_wr   = 1'b1;
            S_FREE_WR:  cmd.free_wr  = 1'b1;
            S_DONE:     cmd.finish   = !sts.out_full;
            default:    cmd = '0;
        endcase
    end
endmodule
`default_nettype wire

>>> rtl/buddy_block_allocator_top.sv
// Top level of the buddy block allocator.
//
//  channel  dir  handshake            payload
//  s_       in   s_tvalid/s_tready    tdata: req_size, free_address, free_order; tuser: op
//  m_       out  m_tvalid/m_tready    tdata: status, grant_address, grant_order
//  cfg_     in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Allocate: the check, then a read and test of each bitmap word scanned (up to POOL_UNITS / 32
// at the lowest order), then a step to take the slot and one per split order. Free: the check,
// then a step to free the block and one per merge. A rejected request goes from the check to
// the result. Each slot, split or merge step is a read-modify-write of the 32-bit bitmap RAM.
// After reset or a top_blocks write a sweep over all 2 * POOL_UNITS / 32 bitmap words
// initialises the bitmap; no word is accepted meanwhile. A stalled result waits in the output
// register while the next word is accepted; the following result holds until that register drains.
`default_nettype none
module buddy_block_allocator_top import bba_pkg::*; #(
    parameter int MIN_ORDER  = DEF_MIN_ORDER,
    parameter int NUM_ORDERS = DEF_NUM_ORDERS,
    parameter int POOL_UNITS = DEF_POOL_UNITS
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // req_size[31:0], free_address[79:32], free_order[85:80]
    input  wire logic [S_DATA_W-1:0]  s_tdata,
    // op[0]
    input  wire logic                 s_tuser,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // status[2:0], grant_address[50:3], grant_order[56:51]
    output logic [M_DATA_W-1:0]       m_tdata,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data
);
    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    bba_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    bba_dp #(
        .MIN_ORDER  (MIN_ORDER),
        .NUM_ORDERS (NUM_ORDERS),
        .POOL_UNITS (POOL_UNITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .sts       (sts)
    );
endmodule
`default_nettype wire

>>> tb/tb_top.sv
// Self-checking testbench for the buddy block allocator top level.
`default_nettype none
module tb_top;
    import bba_pkg::*;

    localparam int MIN_ORD   = DEF_MIN_ORDER;
    localparam int N_ORD     = DEF_NUM_ORDERS;
    localparam int UNITS     = DEF_POOL_UNITS;
    localparam int MAX_ORD   = MIN_ORD + N_ORD - 1;
    localparam int TOP_LIMIT = UNITS >> (N_ORD - 1);
    localparam int WDOG_MAX  = 4000;
    localparam int HOLD_LEN  = 400;

    typedef enum logic {OP_ALLOC = 1'b0, OP_FREE = 1'b1} op_t;

    typedef struct {
        op_t                op;
        logic [SIZE_W-1:0]  size;
        logic [ADDR_W-1:0]  addr;
        logic [ORD_W-1:0]   order;
    } req_t;

    typedef struct {
        res_t               status;
        logic [ADDR_W-1:0]  addr;
        logic [ORD_W-1:0]   order;
    } grant_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata = '0;
    logic                 s_tuser = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_DATA_W-1:0]  m_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_POOL_BASE;
    logic [CFG_W-1:0]     cfg_data = '0;

    buddy_block_allocator_top dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Allocator shadow state
    bit                busy_map [N_ORD][UNITS];
    logic [CNT_W-1:0]  free_cnt [N_ORD];
    logic [ADDR_W-1:0] base_reg = '0;
    logic [TOP_W-1:0]  top_reg = TOP_RESET;

    req_t   pending_reqs[$];
    grant_t expected_grants[$];
    grant_t live_blocks[$];
    bit     failed = 1'b0;
    bit     no_idle = 1'b0;
    int     words_out = 0;

    function automatic int usable_top();
        int t;
        t = top_reg;
        if (t > TOP_LIMIT) t = TOP_LIMIT;
        if (t == 0) t = 1;
        return t;
    endfunction

    function automatic bit slot_busy(int lv, longint idx);
        if (idx >= (UNITS >> lv)) return 1'b1;
        return busy_map[lv][idx];
    endfunction

    function automatic void set_slot(int lv, longint idx, bit v);
        if (idx < (UNITS >> lv)) busy_map[lv][idx] = v;
    endfunction

    function automatic void rebuild_maps();
        for (int lv = 0; lv < N_ORD; lv++) begin
            free_cnt[lv] = '0;
            for (int i = 0; i < UNITS; i++) busy_map[lv][i] = 1'b1;
        end
        for (int i = 0; i < usable_top(); i++) set_slot(N_ORD - 1, i, 1'b0);
        free_cnt[N_ORD-1] = CNT_W'(usable_top());
    endfunction

    function automatic grant_t predict_alloc(logic [SIZE_W-1:0] size);
        grant_t g;
        int     target;
        int     lv;
        longint idx;
        g = '{RES_OK, '0, '0};
        if (size == 0 || longint'(size) > (longint'(1) << MAX_ORD)) begin
            g.status = RES_BAD_SIZE;
            return g;
        end
        target = 0;
        while ((longint'(1) << (MIN_ORD + target)) < longint'(size)) target++;
        lv = target;
        while (lv < N_ORD && free_cnt[lv] == 0) lv++;
        if (lv >= N_ORD) begin
            g.status = RES_NOMEM;
            return g;
        end
        idx = 0;
        while (idx < (UNITS >> lv) && slot_busy(lv, idx)) idx++;
        if (idx >= (UNITS >> lv)) begin
            g.status = RES_NOMEM;
            return g;
        end
        set_slot(lv, idx, 1'b1);
        free_cnt[lv] = free_cnt[lv] - 1'b1;
        // split leftwards, leave each right half free
        while (lv > target) begin
            lv--;
            idx = idx << 1;
            set_slot(lv, idx, 1'b1);
            set_slot(lv, idx + 1, 1'b0);
            free_cnt[lv] = free_cnt[lv] + 1'b1;
        end
        g.addr  = base_reg + ADDR_W'(idx << (MIN_ORD + target));
        g.order = ORD_W'(MIN_ORD + target);
        return g;
    endfunction

    function automatic grant_t predict_free(logic [ADDR_W-1:0] addr, logic [ORD_W-1:0] order);
        grant_t            g;
        longint            t;
        logic [ADDR_W-1:0] off;
        int                lv;
        longint            idx;
        longint            bud;
        g = '{RES_OK, '0, '0};
        t = usable_top();
        if (order < MIN_ORD || order > MAX_ORD) begin
            g.status = RES_BAD_ORDER;
            return g;
        end
        off = addr - base_reg;
        if (addr < base_reg || longint'(off) >= (t << MAX_ORD) ||
            (longint'(off) & ((longint'(1) << order) - 1)) != 0) begin
            g.status = RES_BAD_BLOCK;
            return g;
        end
        lv  = order - MIN_ORD;
        idx = longint'(off) >> order;
        set_slot(lv, idx, 1'b0);
        free_cnt[lv] = free_cnt[lv] + 1'b1;
        while (lv < N_ORD - 1) begin
            bud = idx ^ 1;
            if (bud >= (t << (N_ORD - 1 - lv)) || slot_busy(lv, bud)) break;
            set_slot(lv, idx, 1'b1);
            set_slot(lv, bud, 1'b1);
            free_cnt[lv] = free_cnt[lv] - 2'd2;
            idx = idx >> 1;
            lv++;
            set_slot(lv, idx, 1'b0);
            free_cnt[lv] = free_cnt[lv] + 1'b1;
        end
        return g;
    endfunction

    // Driver: predict on acceptance, then offer the next word
    always @(posedge aclk) begin
        req_t cur;
        req_t nxt;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                cur.op    = op_t'(s_tuser);
                cur.size  = s_tdata[31:0];
                cur.addr  = s_tdata[79:32];
                cur.order = s_tdata[85:80];
                expected_grants.push_back(cur.op == OP_ALLOC ? predict_alloc(cur.size) :
                                          predict_free(cur.addr, cur.order));
            end
            if ((!s_tvalid || s_tready) ) begin
                if (pending_reqs.size() != 0 && (no_idle || $urandom_range(99) >= 30)) begin
                    nxt = pending_reqs.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= nxt.op;
                    s_tdata  <= {2'b00, nxt.order, nxt.addr, nxt.size};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver back-pressure, with one long hold-off while words are still queued
    int  hold_left = 0;
    bit  held = 1'b0;
    always @(posedge aclk) begin
        if (!held && words_out >= 150 && pending_reqs.size() > 8) begin
            held      = 1'b1;
            hold_left = HOLD_LEN;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= no_idle || $urandom_range(99) >= 30;
        end
    end

    // Monitor
    always @(posedge aclk) begin
        grant_t exp_g;
        grant_t got;
        if (aresetn && m_tvalid && m_tready) begin
            words_out++;
            got.status = res_t'(m_tdata[2:0]);
            got.addr   = m_tdata[50:3];
            got.order  = m_tdata[56:51];
            if (expected_grants.size() == 0) begin
                $display("%0t: unexpected result word %h", $time, m_tdata);
                failed = 1'b1;
            end else begin
                exp_g = expected_grants.pop_front();
                if (got.status !== exp_g.status) begin
                    $display("%0t: status expected %0d got %0d", $time, exp_g.status, got.status);
                    failed = 1'b1;
                end
                if (got.addr !== exp_g.addr) begin
                    $display("%0t: grant_address expected %h got %h", $time, exp_g.addr, got.addr);
                    failed = 1'b1;
                end
                if (got.order !== exp_g.order) begin
                    $display("%0t: grant_order expected %0d got %0d", $time, exp_g.order, got.order);
                    failed = 1'b1;
                end
                if (exp_g.status == RES_OK && exp_g.order != 0) live_blocks.push_back(exp_g);
            end
        end
    end

    // Watchdog on cycles without any handshake
    int idle_cycles = 0;
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX) begin
            $display("buddy_block_allocator_top test failed");
            $finish;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_POOL_BASE) begin
            base_reg = val;
        end else begin
            top_reg = val[TOP_W-1:0];
            rebuild_maps();
            live_blocks.delete();
        end
    endtask

    task automatic drain();
        while (pending_reqs.size() != 0 || expected_grants.size() != 0 || s_tvalid)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic add_req(op_t op, logic [SIZE_W-1:0] size,
                           logic [ADDR_W-1:0] addr, logic [ORD_W-1:0] order);
        pending_reqs.push_back('{op, size, addr, order});
    endtask

    initial begin
        int     issued;
        int     k;
        int     o;
        grant_t blk;
        rebuild_maps();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: size limits, order limits, bounds and alignment
        add_req(OP_ALLOC, 32'd0, '0, '0);
        add_req(OP_ALLOC, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 6'd63);
        add_req(OP_ALLOC, 32'h0040_0001, '0, '0);
        add_req(OP_ALLOC, 32'h0040_0000, '0, '0);
        add_req(OP_ALLOC, 32'd1, '0, '0);
        add_req(OP_ALLOC, 32'd4097, '0, '0);
        add_req(OP_ALLOC, 32'h0040_0000, '0, '0);
        add_req(OP_FREE, '0, 48'h0, 6'd0);
        add_req(OP_FREE, '0, 48'h0, 6'd11);
        add_req(OP_FREE, '0, 48'h0, 6'd23);
        add_req(OP_FREE, '0, 48'h0, 6'd63);
        add_req(OP_FREE, '0, 48'hFFFF_FFFF_FFFF, 6'd12);
        add_req(OP_FREE, '0, 48'h0100_0000, 6'd12);
        add_req(OP_FREE, '0, 48'h0000_0800, 6'd12);
        add_req(OP_FREE, '0, 48'h0, 6'd12);
        add_req(OP_FREE, '0, 48'h0, 6'd12);   // double free
        add_req(OP_ALLOC, 32'd4096, '0, '0);
        add_req(OP_ALLOC, 32'd8192, '0, '0);
        issued = pending_reqs.size();
        drain();
        write_reg(CFG_POOL_BASE, 48'hFFFF_FFFF_FFFF);
        add_req(OP_FREE, '0, 48'h0, 6'd12);
        add_req(OP_ALLOC, 32'd100, '0, '0);
        add_req(OP_FREE, '0, 48'hFFFF_FFFF_FFFF, 6'd12);
        issued += 3;
        drain();

        // random phases: allocate a batch, then free what was granted plus noise
        k = 0;
        while (issued < 750) begin
            case (k)
                0: write_reg(CFG_TOP_BLOCKS, 48'd0);
                1: write_reg(CFG_TOP_BLOCKS, 48'd7);
                2: write_reg(CFG_TOP_BLOCKS, 48'd1);
                3: write_reg(CFG_TOP_BLOCKS, 48'd4);
                default: write_reg(CFG_TOP_BLOCKS, CFG_W'($urandom_range(7)));
            endcase
            write_reg(CFG_POOL_BASE, (k == 1) ? 48'hFFFF_FFFF_F000 :
                      (k == 0) ? 48'h0 : ADDR_W'({$urandom, $urandom}));
            no_idle = (k == 2);
            repeat ($urandom_range(30, 50)) begin
                if ($urandom_range(19) == 0) begin
                    add_req(OP_ALLOC, $urandom, ADDR_W'({$urandom, $urandom}),
                            ORD_W'($urandom));
                end else begin
                    o = ($urandom_range(3) == 0) ? $urandom_range(0, 10) : $urandom_range(0, 2);
                    add_req(OP_ALLOC, SIZE_W'($urandom_range(1, 1 << (MIN_ORD + o))),
                            ADDR_W'({$urandom, $urandom}), ORD_W'($urandom));
                end
                issued++;
            end
            drain();
            while (live_blocks.size() != 0) begin
                o = $urandom_range(live_blocks.size() - 1);
                blk = live_blocks[o];
                if ($urandom_range(9) != 0) live_blocks.delete(o);
                add_req(OP_FREE, $urandom, blk.addr, blk.order);
                if ($urandom_range(9) == 0)
                    add_req(OP_FREE, $urandom, ADDR_W'({$urandom, $urandom}),
                            ORD_W'($urandom));
                issued++;
            end
            add_req(OP_ALLOC, 32'd1, '0, '0);
            issued++;
            drain();
            k++;
        end
        no_idle = 1'b0;
        drain();
        if (!failed && expected_grants.size() == 0)
            $display("buddy_block_allocator_top test passed");
        else
            $display("buddy_block_allocator_top test failed");
        $finish;
    end
endmodule
`default_nettype wire
